// File: src/b85_pkg.sv
// Shared types, constants and the symbol lookup for the base85 group decoder.
package b85_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned CntW  = 3;
    localparam logic [WordW-1:0] LimitBeforeLast = 32'h0303_0303;
    localparam logic [CntW-1:0]  GroupDigits     = 3'd5;

    typedef struct packed {
        logic       ok;
        logic [6:0] digit;
    } sym_t;

    // One completed group (or one error beat) waiting to be sent out.
    typedef struct packed {
        logic [WordW-1:0] word;
        logic [CntW-1:0]  nbytes;
        logic             bad;
        logic             ovf;
        logic             msg_end;
    } grp_t;

    function automatic sym_t symbol_value(input logic [7:0] c);
        sym_t r;
        r.ok    = 1'b1;
        r.digit = '0;
        case (c) inside
            [8'h30:8'h39]: r.digit = 7'(c - 8'h30);
            [8'h41:8'h5A]: r.digit = 7'(c - 8'h41) + 7'd10;
            [8'h61:8'h7A]: r.digit = 7'(c - 8'h61) + 7'd36;
            8'h21: r.digit = 7'd62;
            8'h23: r.digit = 7'd63;
            8'h24: r.digit = 7'd64;
            8'h25: r.digit = 7'd65;
            8'h26: r.digit = 7'd66;
            8'h28: r.digit = 7'd67;
            8'h29: r.digit = 7'd68;
            8'h2A: r.digit = 7'd69;
            8'h2B: r.digit = 7'd70;
            8'h2D: r.digit = 7'd71;
            8'h3B: r.digit = 7'd72;
            8'h3C: r.digit = 7'd73;
            8'h3D: r.digit = 7'd74;
            8'h3E: r.digit = 7'd75;
            8'h3F: r.digit = 7'd76;
            8'h40: r.digit = 7'd77;
            8'h5E: r.digit = 7'd78;
            8'h5F: r.digit = 7'd79;
            8'h60: r.digit = 7'd80;
            8'h7B: r.digit = 7'd81;
            8'h7C: r.digit = 7'd82;
            8'h7D: r.digit = 7'd83;
            8'h7E: r.digit = 7'd84;
            default: r.ok = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// File: src/b85_dec.sv
// Character decoder: accumulates digits and builds one record per completed group or error beat.
module b85_dec
    import b85_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic [7:0]       symbol,
    input  logic [2:0]       group_bytes,
    input  logic             message_end,
    output logic             push,
    output grp_t             grp
);

    logic [WordW-1:0] acc_reg, acc_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic             skip_reg, skip_next;

    sym_t             sv;
    logic [WordW-1:0] acc_mul;
    logic [CntW-1:0]  cnt_inc;
    logic             ovf_now;
    logic [CntW-1:0]  nb;

    assign sv      = symbol_value(symbol);
    // acc*85 = acc*64 + acc*16 + acc*4 + acc, kept to 32 bits
    assign acc_mul = (acc_reg << 6) + (acc_reg << 4) + (acc_reg << 2) + acc_reg
                     + WordW'(sv.digit);
    assign cnt_inc = cnt_reg + 3'd1;
    assign ovf_now = ovf_reg | ((cnt_reg >= 3'd4) &&
                     ((acc_reg > LimitBeforeLast) ||
                      ((acc_reg == LimitBeforeLast) && (sv.digit != 7'd0))));

    always_comb
    begin
        case (group_bytes) inside
            3'd0:          nb = 3'd1;
            [3'd5:3'd7]:   nb = 3'd4;
            default:       nb = group_bytes;
        endcase
    end

    always_comb
    begin
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        skip_next = skip_reg;
        push      = 1'b0;
        grp.word    = acc_mul;
        grp.nbytes  = nb;
        grp.bad     = 1'b0;
        grp.ovf     = ovf_now;
        grp.msg_end = message_end;
        if (in_fire) begin
            if (skip_reg) begin
                if (message_end) begin
                    acc_next  = '0;
                    cnt_next  = '0;
                    ovf_next  = 1'b0;
                    skip_next = 1'b0;
                end
            end else if (!sv.ok) begin
                push        = 1'b1;
                grp.word    = '0;
                grp.nbytes  = 3'd1;
                grp.bad     = 1'b1;
                grp.ovf     = 1'b0;
                grp.msg_end = 1'b1;
                acc_next    = '0;
                cnt_next    = '0;
                ovf_next    = 1'b0;
                skip_next   = !message_end;
            end else if (cnt_inc == GroupDigits) begin
                push     = 1'b1;
                acc_next = '0;
                cnt_next = '0;
                ovf_next = 1'b0;
            end else if (message_end) begin
                acc_next = '0;
                cnt_next = '0;
                ovf_next = 1'b0;
            end else begin
                acc_next = acc_mul;
                cnt_next = cnt_inc;
                ovf_next = ovf_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            acc_reg  <= '0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
            skip_reg <= 1'b0;
        end else begin
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            ovf_reg  <= ovf_next;
            skip_reg <= skip_next;
        end
    end

endmodule

// File: src/b85_ser.sv
// Group holding register and byte serializer driving the output beat register.
module b85_ser
    import b85_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  grp_t       grp,
    output logic       hold_free,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_byte,
    output logic       bad_symbol,
    output logic       overflow,
    output logic       last_of_group,
    output logic       last_of_message
);

    logic             hold_valid_reg, hold_valid_next;
    grp_t             hold_reg, hold_next;
    logic             ov_reg, ov_next;
    logic [WordW-1:0] word_reg, word_next;
    logic [CntW-1:0]  left_reg, left_next;
    logic             bad_reg, bad_next;
    logic             ovf_reg, ovf_next;
    logic             end_reg, end_next;

    logic out_fire, last_beat, ser_free, pop;

    assign out_fire  = ov_reg & out_ready;
    assign last_beat = (left_reg == 3'd1);
    assign ser_free  = !ov_reg | (out_fire & last_beat);
    assign pop       = hold_valid_reg & ser_free;
    assign hold_free = !hold_valid_reg | pop;

    assign out_valid       = ov_reg;
    assign data_byte       = word_reg[WordW-1 -: 8];
    assign bad_symbol      = bad_reg;
    assign overflow        = ovf_reg;
    assign last_of_group   = last_beat;
    assign last_of_message = last_beat & end_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        if (push) begin
            hold_valid_next = 1'b1;
            hold_next       = grp;
        end else if (pop) begin
            hold_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        ov_next   = ov_reg;
        word_next = word_reg;
        left_next = left_reg;
        bad_next  = bad_reg;
        ovf_next  = ovf_reg;
        end_next  = end_reg;
        if (pop) begin
            ov_next   = 1'b1;
            word_next = hold_reg.word;
            left_next = hold_reg.nbytes;
            bad_next  = hold_reg.bad;
            ovf_next  = hold_reg.ovf;
            end_next  = hold_reg.msg_end;
        end else if (out_fire) begin
            if (last_beat) begin
                ov_next = 1'b0;
            end else begin
                word_next = word_reg << 8;
                left_next = left_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_valid_reg <= 1'b0;
            ov_reg         <= 1'b0;
            left_reg       <= '0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            ov_reg         <= ov_next;
            left_reg       <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        word_reg <= word_next;
        bad_reg  <= bad_next;
        ovf_reg  <= ovf_next;
        end_reg  <= end_next;
    end

endmodule

// File: src/base85_group_decoder.sv
// Top level of the base85 group decoder.
// Input stream: one character per beat. s_tdata[7:0] is the character,
// s_tdata[10:8] the byte count for a group completed by this character
// (4 except on the final group), s_tlast marks the last character of a message.
// Output stream: one decoded byte per beat, most significant byte first.
// m_tuser flags the beat: bad character, group overflow, last byte of group;
// m_tlast marks the final byte of the message.
// Every fifth valid character completes a group that yields 1 to 4 bytes.
// A bad character gives a single error beat and the rest of its message is dropped.
// Throughput: one character per cycle while s_tready is high; the decode (lookup, multiply
// by 85, overflow compare) is combinational logic into the state and a holding register.
// A completed group goes through the holding register, then the output beat register,
// and is sent from there one byte per cycle while m_tready is high.
// A stalled receiver holds the current byte; one further group waits in the
// holding register and s_tready drops only when that register is also full.
// Reset clears the accumulator, digit count, skip state and both buffers.
module base85_group_decoder
    import b85_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [7:0] symbol, [10:8] group_bytes, rest zero
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // [7:0] data_byte
    output logic [2:0]  m_tuser,  // [0] bad_symbol, [1] overflow, [2] last_of_group
    output logic        m_tlast
);

    logic in_fire;
    logic push;
    grp_t grp;
    logic hold_free;

    assign s_tready = hold_free;
    assign in_fire  = s_tvalid & hold_free;

    b85_dec u_dec (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .symbol      (s_tdata[7:0]),
        .group_bytes (s_tdata[10:8]),
        .message_end (s_tlast),
        .push        (push),
        .grp         (grp)
    );

    b85_ser u_ser (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .grp             (grp),
        .hold_free       (hold_free),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .data_byte       (m_tdata),
        .bad_symbol      (m_tuser[0]),
        .overflow        (m_tuser[1]),
        .last_of_group   (m_tuser[2]),
        .last_of_message (m_tlast)
    );

endmodule

// File: tb/tb.sv
// Self-checking testbench for the base85 group decoder: directed and random character streams.
module tb;
    import b85_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_SHOWN   = 40;
    localparam int RANDOM_CHARS = 250;

    // '!' in the low byte up to '~' in the high byte: digits 62..84
    localparam logic [183:0] PUNCT = {
        8'h7E, 8'h7D, 8'h7C, 8'h7B, 8'h60, 8'h5F, 8'h5E, 8'h40,
        8'h3F, 8'h3E, 8'h3D, 8'h3C, 8'h3B, 8'h2D, 8'h2B, 8'h2A,
        8'h29, 8'h28, 8'h26, 8'h25, 8'h24, 8'h23, 8'h21};

    typedef struct packed {
        logic [7:0] data;
        logic       bad;
        logic       ovf;
        logic       grp_last;
        logic       msg_last;
    } out_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // decoder model state
    logic [31:0] acc_word;
    logic [2:0]  digit_cnt;
    logic        group_ovf;
    logic        skip_msg;

    out_beat_t pending_bytes[$];
    int errors;
    int cycles;
    int chars_counted;
    int beats_seen;
    int bad_beats;
    int ovf_beats;
    int rx_stall;
    bit calm_in;
    bit calm_out;

    base85_group_decoder i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d bytes still expected", cycles,
                     pending_bytes.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic char_digit(input logic [7:0] c, output logic [6:0] d);
        d = '0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d = 7'(c - 8'h30);
            return 1'b1;
        end
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            d = 7'(c - 8'h41 + 8'd10);
            return 1'b1;
        end
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            d = 7'(c - 8'h61 + 8'd36);
            return 1'b1;
        end
        for (int k = 0; k < 23; k++)
        begin
            if (PUNCT[k*8 +: 8] == c)
            begin
                d = 7'(62 + k);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10)
            return 8'(8'h30 + d);
        if (d < 36)
            return 8'(8'h41 + d - 10);
        if (d < 62)
            return 8'(8'h61 + d - 36);
        return PUNCT[(d-62)*8 +: 8];
    endfunction

    function automatic void clear_group();
        acc_word  = '0;
        digit_cnt = '0;
        group_ovf = 1'b0;
    endfunction

    // Advance the decoder model by one accepted character and queue its output bytes.
    function automatic void predict_decode(input logic [7:0] sym, input logic [2:0] gb,
                                           input logic eom);
        logic [6:0] d;
        int nbytes;
        out_beat_t b;
        chars_counted++;
        if (skip_msg)
        begin
            if (eom)
            begin
                clear_group();
                skip_msg = 1'b0;
            end
            return;
        end
        if (!char_digit(sym, d))
        begin
            b = '{data: 8'h00, bad: 1'b1, ovf: 1'b0, grp_last: 1'b1, msg_last: 1'b1};
            pending_bytes.push_back(b);
            clear_group();
            skip_msg = !eom;
            return;
        end
        if (digit_cnt == 3'd4)
        begin
            if (acc_word > LimitBeforeLast || (acc_word == LimitBeforeLast && d != 0))
                group_ovf = 1'b1;
        end
        acc_word  = acc_word * 32'd85 + {25'b0, d};
        digit_cnt = digit_cnt + 3'd1;
        if (digit_cnt < 3'd5)
        begin
            if (eom)
                clear_group();
            return;
        end
        nbytes = (gb == 3'd0) ? 1 : (gb > 3'd4) ? 4 : int'(gb);
        for (int k = 0; k < nbytes; k++)
        begin
            b.data     = acc_word[31:24];
            b.bad      = 1'b0;
            b.ovf      = group_ovf;
            b.grp_last = (k == nbytes - 1);
            b.msg_last = (k == nbytes - 1) && eom;
            pending_bytes.push_back(b);
            acc_word = acc_word << 8;
        end
        clear_group();
    endfunction

    task automatic send_char(input logic [7:0] sym, input logic [2:0] gb, input logic eom);
        int gap;
        gap = calm_in ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, gb, sym};
        s_tlast  <= eom;
        do
            @(posedge clk);
        while (!s_tready);
        predict_decode(sym, gb, eom);
    endtask

    // Five characters, first one in the high byte; gb and eom go on the fifth.
    task automatic send_group(input logic [39:0] chars, input logic [2:0] gb,
                              input logic eom);
        for (int i = 4; i >= 0; i--)
            send_char(chars[i*8 +: 8], (i == 0) ? gb : 3'd4, (i == 0) ? eom : 1'b0);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] random_digit_char();
        if ($urandom_range(0, 3) == 0)
            return digit_char($urandom_range(80, 84));
        return digit_char($urandom_range(0, 84));
    endfunction

    function automatic logic [7:0] random_bad_char();
        logic [7:0] c;
        logic [6:0] d;
        do
            c = 8'($urandom_range(0, 255));
        while (char_digit(c, d));
        return c;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= MAX_SHOWN)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // output side: random backpressure and comparison of every beat
    always @(posedge clk)
    begin : rx_side
        out_beat_t want;
        if (m_tvalid && m_tready)
        begin
            beats_seen++;
            if (m_tuser[0])
                bad_beats++;
            if (m_tuser[1])
                ovf_beats++;
            if (pending_bytes.size() == 0)
            begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("%0t: unexpected beat, expected none, got data %0h user %b last %b",
                             $time, m_tdata, m_tuser, m_tlast);
            end
            else
            begin
                want = pending_bytes.pop_front();
                check_field("data_byte", want.data, m_tdata);
                check_field("bad_symbol", 8'(want.bad), 8'(m_tuser[0]));
                check_field("overflow", 8'(want.ovf), 8'(m_tuser[1]));
                check_field("last_of_group", 8'(want.grp_last), 8'(m_tuser[2]));
                check_field("last_of_message", 8'(want.msg_last), 8'(m_tlast));
            end
            rx_stall = calm_out ? 0 : $urandom_range(0, 15);
        end
        if (rx_stall > 0)
        begin
            m_tready <= 1'b0;
            rx_stall--;
        end
        else
            m_tready <= 1'b1;
    end

    // zero group, largest value without overflow, smallest value that wraps
    task automatic test_group_extremes();
        send_group({8'h30, 8'h30, 8'h30, 8'h30, 8'h30}, 3'd4, 1'b0);
        send_group({8'h7C, 8'h4E, 8'h73, 8'h43, 8'h30}, 3'd0, 1'b0);
        send_group({8'h7C, 8'h4E, 8'h73, 8'h43, 8'h31}, 3'd7, 1'b1);
        wait_drained();
    endtask

    // bad character mid-message, skipped tail, bad character on the message end
    task automatic test_bad_symbols();
        send_char(8'h61, 3'd4, 1'b0);
        send_char(8'h62, 3'd4, 1'b0);
        send_char(8'hFF, 3'd4, 1'b0);
        send_char(8'h78, 3'd4, 1'b1);
        send_char(8'h00, 3'd4, 1'b1);
    endtask

    // message ending inside a group drops the partial value
    task automatic test_partial_end();
        send_char(8'h7E, 3'd6, 1'b0);
        send_char(8'h32, 3'd5, 1'b1);
        send_group({8'h32, 8'h7E, 8'h21, 8'h41, 8'h7A}, 3'd3, 1'b1);
    endtask

    task automatic send_message();
        int groups;
        int kind;
        int total;
        int bad_at;
        logic [7:0] sym;
        logic [2:0] gb;
        logic eom;
        groups = $urandom_range(1, 4);
        kind   = $urandom_range(0, 9);
        total  = groups * 5 + ((kind == 1) ? $urandom_range(1, 4) : 0);
        bad_at = (kind == 0) ? $urandom_range(0, total - 1) : -1;
        for (int i = 0; i < total; i++)
        begin
            sym = (i == bad_at) ? random_bad_char() : random_digit_char();
            eom = (i == total - 1);
            if (i % 5 != 4)
                gb = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
            else if (i / 5 == groups - 1)
                gb = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                 : 3'($urandom_range(1, 4));
            else
                gb = 3'd4;
            send_char(sym, gb, eom);
        end
    endtask

    task automatic test_random_stream();
        int start;
        bit paused;
        start  = chars_counted;
        paused = 1'b0;
        while (chars_counted - start < RANDOM_CHARS)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                calm_in  = ($urandom_range(0, 2) == 0);
                calm_out = ($urandom_range(0, 2) == 0);
            end
            if (!paused && chars_counted - start > RANDOM_CHARS / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
            if ($urandom_range(0, 7) == 0)
                send_char(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                          1'($urandom_range(0, 1)));
            else
                send_message();
        end
        calm_in  = 1'b0;
        calm_out = 1'b0;
    endtask

    initial
    begin
        acc_word  = '0;
        digit_cnt = '0;
        group_ovf = 1'b0;
        skip_msg  = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_group_extremes();
        test_bad_symbols();
        test_partial_end();
        test_random_stream();
        wait_drained();
        repeat (12) @(posedge clk);
        $display("Covered %0d characters and %0d output beats", chars_counted,
                 beats_seen);
        $display("including %0d bad-character beats and %0d overflow beats", bad_beats,
                 ovf_beats);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: base85_group_decoder.f
src/b85_pkg.sv
src/b85_dec.sv
src/b85_ser.sv
src/base85_group_decoder.sv
tb/tb.sv
